// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SISLSU_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SISLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sislsu_pkg.sv =====
// ----------------------------------------------------------------------------
// sislsu_pkg
// Types and constants of the SIS ring lattice sweep update block.
// ----------------------------------------------------------------------------
`default_nettype none

package sislsu_pkg;

    localparam int MAX_SITES_DEF = 131072;
    localparam int FRACTION_BITS = 32;

    localparam int SITE_COUNT_W = 18;
    localparam int SWEEP_W      = 20;
    localparam int THRESH_W     = 33;
    localparam int RAND_W       = 32;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_SITE_COUNT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWEEP_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;

    localparam logic [SITE_COUNT_W-1:0] SITE_COUNT_RST  = 18'd131072;
    localparam logic [SWEEP_W-1:0]      SWEEP_LIMIT_RST = 20'd131072;
    localparam logic [THRESH_W-1:0]     THRESHOLD_RST   = 33'd0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_VISIT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [RAND_W-1:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [SITE_COUNT_W-1:0] active_count;
        logic [SWEEP_W-1:0]      sweeps_done;
        logic                    run_over;
        logic                    extinct;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/sislsu_site_mem.sv =====
// ----------------------------------------------------------------------------
// sislsu_site_mem
// One-bit site store with registered read. A fill mark tracks the written
// prefix; entries at or beyond it read as active.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sislsu_site_mem #(
    parameter int DEPTH = 131072,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_bit,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_bit
);

    logic              mem_array [0:DEPTH-1];
    logic              rd_data_reg;
    logic              rd_hit_reg;
    logic [ADDR_W:0]   fill_reg;
    logic [ADDR_W:0]   fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_bit;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (clear)
        begin
            fill_next = '0;
        end
        else if (wr_en && ({1'b0, wr_addr} >= fill_reg))
        begin
            fill_next = {1'b0, wr_addr} + (ADDR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_hit_reg <= ({1'b0, rd_addr} < fill_reg);
        end
    end

    assign rd_bit = rd_data_reg | ~rd_hit_reg;

    `SISLSU_ASSERT(a_fill_bound, 1'b1, fill_reg <= (ADDR_W+1)'(DEPTH), "fill mark beyond depth")
    `SISLSU_ASSERT_NEXT(a_clear_fill, clear, fill_reg == '0, "fill mark not cleared")

endmodule

`default_nettype wire

// ===== sv/sis_lattice_sweep_update_top.sv =====
// ----------------------------------------------------------------------------
// sis_lattice_sweep_update_top
// SIS contact process on a ring of one-bit sites, one site visit per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: action START resets the run (all sites active, sweep and
//   site index cleared); action VISIT updates the next site from random_fraction.
//   result channel: one transfer at each sweep end with the active count,
//   sweep number, run_over and extinct. After run_over, visits are dropped
//   until the next START.
//   APB port: site_count at 0x00, sweep_limit at 0x08, deactivate_threshold
//   at 0x10; they must be written only while the block is idle, which the
//   block itself does not enforce. A START or a dropped visit leaves the
//   block idle for the next item. A visit passes S_RD_L, S_RD_R and S_UPD
//   before the next item is taken, set by three reads (site, left, right)
//   through the single read port of the site store; a sweep end adds S_SWEEP.
//   result_valid is registered in S_SWEEP, after the last visit of a sweep.
//   Reset: all sites read active with no clearing pass; sweep and index clear.
//   A stalled result holds in the output register; the next item is still
//   taken, and the following sweep end waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sis_lattice_sweep_update_top #(
    parameter int MAX_SITES = sislsu_pkg::MAX_SITES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sislsu_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sislsu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sislsu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                     pready,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire sislsu_pkg::item_t                   item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output sislsu_pkg::result_t                      result
);

    localparam int ADDR_W = $clog2(MAX_SITES);
    localparam int CNT_W  = $clog2(MAX_SITES + 1);
    localparam int CW     = (CNT_W > sislsu_pkg::SITE_COUNT_W) ? CNT_W
                                                               : sislsu_pkg::SITE_COUNT_W;
    localparam int PROD_W = sislsu_pkg::RAND_W + CNT_W + 1;
    localparam int TEN_W  = CNT_W + 4;
    localparam int SC_RST = int'(sislsu_pkg::SITE_COUNT_RST);
    localparam int ACT_RST_INT = (SC_RST < 3) ? 3 : ((SC_RST > MAX_SITES) ? MAX_SITES
                                                                           : SC_RST);
    localparam logic [CNT_W-1:0] ACT_RST = CNT_W'(ACT_RST_INT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD_L  = 5'b00010,
        S_RD_R  = 5'b00100,
        S_UPD   = 5'b01000,
        S_SWEEP = 5'b10000
    } state_t;

    // configuration
    logic [sislsu_pkg::SITE_COUNT_W-1:0] site_count_reg;
    logic [sislsu_pkg::SWEEP_W-1:0]      sweep_limit_reg;
    logic [sislsu_pkg::THRESH_W-1:0]     threshold_reg;
    logic                                cfg_we;
    logic [sislsu_pkg::REG_IDX_W-1:0]    reg_idx;

    // control state
    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              idx_reg, idx_next;
    logic [sislsu_pkg::SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]               act_reg, act_next;
    logic                           stopped_reg, stopped_next;
    logic                           result_valid_reg, result_valid_next;

    // payload
    logic [ADDR_W-1:0]              cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0]               l_reg, l_next;
    logic [sislsu_pkg::RAND_W-1:0]  u_reg, u_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic                           cur_bit_reg, cur_bit_next;
    logic                           left_bit_reg, left_bit_next;
    sislsu_pkg::result_t            result_reg, result_next;

    // datapath
    logic [CW-1:0]                  sc_ext;
    logic [CW-1:0]                  l_clamp;
    logic [CNT_W-1:0]               l_eff;
    logic [ADDR_W-1:0]              start_idx;
    logic [CNT_W-1:0]               nxt_ext;
    logic                           last_site;
    logic [ADDR_W-1:0]              left_idx;
    logic [ADDR_W-1:0]              right_idx;
    logic [CNT_W:0]                 quot;
    logic [CNT_W:0]                 act_n;
    logic                           infect;
    logic                           recover;
    logic                           new_bit;
    logic [sislsu_pkg::SWEEP_W-1:0] sweep_inc;
    logic [TEN_W-1:0]               ten_a;
    logic                           extinct;
    logic                           over;
    logic [CW-1:0]                  act_wide;
    logic                           accept;

    // site store port
    logic                           mem_clear;
    logic [ADDR_W-1:0]              mem_rd_addr;
    logic                           mem_rd_bit;
    logic                           mem_wr_en;

    // ------------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign reg_idx = paddr[sislsu_pkg::APB_ADDR_W-1:sislsu_pkg::REG_IDX_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg  <= sislsu_pkg::SITE_COUNT_RST;
            sweep_limit_reg <= sislsu_pkg::SWEEP_LIMIT_RST;
            threshold_reg   <= sislsu_pkg::THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                sislsu_pkg::REG_SITE_COUNT:
                    site_count_reg <= pwdata[sislsu_pkg::SITE_COUNT_W-1:0];
                sislsu_pkg::REG_SWEEP_LIMIT:
                    sweep_limit_reg <= pwdata[sislsu_pkg::SWEEP_W-1:0];
                sislsu_pkg::REG_THRESHOLD:
                    threshold_reg <= pwdata[sislsu_pkg::THRESH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sislsu_pkg::REG_SITE_COUNT:
                prdata = sislsu_pkg::APB_DATA_W'(site_count_reg);
            sislsu_pkg::REG_SWEEP_LIMIT:
                prdata = sislsu_pkg::APB_DATA_W'(sweep_limit_reg);
            sislsu_pkg::REG_THRESHOLD:
                prdata = sislsu_pkg::APB_DATA_W'(threshold_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Site addressing
    // ------------------------------------------------------------------------
    assign sc_ext = CW'(site_count_reg);

    always_comb
    begin
        if (sc_ext < CW'(3))
        begin
            l_clamp = CW'(3);
        end
        else if (sc_ext > CW'(MAX_SITES))
        begin
            l_clamp = CW'(MAX_SITES);
        end
        else
        begin
            l_clamp = sc_ext;
        end
    end

    assign l_eff     = CNT_W'(l_clamp);
    assign start_idx = (CNT_W'(idx_reg) >= l_eff) ? '0 : idx_reg;
    assign nxt_ext   = CNT_W'(cur_idx_reg) + CNT_W'(1);
    assign last_site = (nxt_ext == l_reg);
    assign left_idx  = (cur_idx_reg == '0) ? ADDR_W'(l_reg - CNT_W'(1))
                                           : cur_idx_reg - ADDR_W'(1);
    assign right_idx = last_site ? '0 : ADDR_W'(nxt_ext);

    // ------------------------------------------------------------------------
    // Site update
    // ------------------------------------------------------------------------
    assign quot = prod_reg[sislsu_pkg::FRACTION_BITS +: CNT_W+1];

    always_comb
    begin
        if (left_bit_reg && mem_rd_bit)
        begin
            act_n = {act_reg, 1'b0};
        end
        else if (left_bit_reg || mem_rd_bit)
        begin
            act_n = {1'b0, act_reg};
        end
        else
        begin
            act_n = '0;
        end
    end

    assign infect  = (quot < act_n);
    assign recover = ({1'b0, u_reg} < threshold_reg);
    assign new_bit = cur_bit_reg ? ~recover : infect;

    assign sweep_inc = sweep_reg + sislsu_pkg::SWEEP_W'(1);
    assign ten_a     = {1'b0, act_reg, 3'b000} + {3'b000, act_reg, 1'b0};
    assign extinct   = (ten_a < TEN_W'(l_reg));
    assign over      = extinct || (sweep_inc >= sweep_limit_reg);
    assign act_wide  = CW'(act_reg);

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid & item_ready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        sweep_next        = sweep_reg;
        act_next          = act_reg;
        stopped_next      = stopped_reg;
        result_valid_next = result_valid_reg;
        cur_idx_next      = cur_idx_reg;
        l_next            = l_reg;
        u_next            = u_reg;
        prod_next         = prod_reg;
        cur_bit_next      = cur_bit_reg;
        left_bit_next     = left_bit_reg;
        result_next       = result_reg;
        mem_clear         = 1'b0;
        mem_wr_en         = 1'b0;
        mem_rd_addr       = cur_idx_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                mem_rd_addr = start_idx;
                if (accept)
                begin
                    if (item.action == sislsu_pkg::ACT_START)
                    begin
                        idx_next     = '0;
                        sweep_next   = '0;
                        act_next     = l_eff;
                        stopped_next = 1'b0;
                        mem_clear    = 1'b1;
                    end
                    else if (!stopped_reg)
                    begin
                        cur_idx_next = start_idx;
                        l_next       = l_eff;
                        u_next       = item.random_fraction;
                        state_next   = S_RD_L;
                    end
                end
            end
            S_RD_L:
            begin
                mem_rd_addr  = left_idx;
                cur_bit_next = mem_rd_bit;
                prod_next    = PROD_W'(u_reg) * PROD_W'({l_reg, 1'b0});
                state_next   = S_RD_R;
            end
            S_RD_R:
            begin
                mem_rd_addr   = right_idx;
                left_bit_next = mem_rd_bit;
                state_next    = S_UPD;
            end
            S_UPD:
            begin
                mem_wr_en = 1'b1;
                if (!cur_bit_reg && infect && (act_reg < CNT_W'(MAX_SITES)))
                begin
                    act_next = act_reg + CNT_W'(1);
                end
                else if (cur_bit_reg && recover && (act_reg != '0))
                begin
                    act_next = act_reg - CNT_W'(1);
                end
                idx_next   = right_idx;
                state_next = last_site ? S_SWEEP : S_IDLE;
            end
            S_SWEEP:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.active_count = act_wide[sislsu_pkg::SITE_COUNT_W-1:0];
                    result_next.sweeps_done  = sweep_inc;
                    result_next.run_over     = over;
                    result_next.extinct      = extinct;
                    result_valid_next        = 1'b1;
                    sweep_next               = sweep_inc;
                    stopped_next             = over;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            sweep_reg        <= '0;
            act_reg          <= ACT_RST;
            stopped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            sweep_reg        <= sweep_next;
            act_reg          <= act_next;
            stopped_reg      <= stopped_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg  <= cur_idx_next;
        l_reg        <= l_next;
        u_reg        <= u_next;
        prod_reg     <= prod_next;
        cur_bit_reg  <= cur_bit_next;
        left_bit_reg <= left_bit_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // Site store
    // ------------------------------------------------------------------------
    sislsu_site_mem #(
        .DEPTH (MAX_SITES)
    ) u_site_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .rd_addr (mem_rd_addr),
        .rd_bit  (mem_rd_bit),
        .wr_en   (mem_wr_en),
        .wr_addr (cur_idx_reg),
        .wr_bit  (new_bit)
    );

    `SISLSU_ASSERT(a_result_from_sweep, $rose(result_valid), $past(state_reg == S_SWEEP), "result raised outside sweep end")
    `SISLSU_ASSERT_NEXT(a_stopped_drop, accept && (item.action == sislsu_pkg::ACT_VISIT) && stopped_reg, (state_reg == S_IDLE) && (idx_reg == $past(idx_reg)), "visit taken after run end")
    `SISLSU_ASSERT(a_site_in_range, state_reg == S_UPD, CNT_W'(cur_idx_reg) < l_reg, "site write beyond site count")
    `SISLSU_ASSERT(a_count_bound, 1'b1, act_reg <= CNT_W'(MAX_SITES), "active count beyond capacity")

endmodule

`default_nettype wire
